// ----- hdl/stwq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwq_pkg
// Shared types and constants of the semaphore table with wait queues.
// ----------------------------------------------------------------------------
package stwq_pkg;

    localparam int OP_W      = 2;
    localparam int SEM_ID_W  = 5;
    localparam int PID_W     = 10;
    localparam int VAL_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int ADDR_LIMIT = 32;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;

    typedef enum logic [OP_W-1:0] {
        OP_INIT   = 2'd0,
        OP_WAIT   = 2'd1,
        OP_SIGNAL = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_FREE    = 2'd1,
        ST_QUEUE_FULL = 2'd2,
        ST_NOTHING    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ALU_INC_SAT  = 2'd0,
        ALU_DEC_SAT  = 2'd1,
        ALU_INC_WRAP = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op                 op;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
    } t_alu_req;

endpackage

// ----- hdl/stwq_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwq_in_if
// Operation channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface stwq_in_if;
    logic                                valid;
    logic                                ready;
    logic [stwq_pkg::OP_W-1:0]           operation;
    logic [stwq_pkg::SEM_ID_W-1:0]       sem_id;
    logic [stwq_pkg::PID_W-1:0]          pid;
    logic signed [stwq_pkg::VAL_W-1:0]   init_value;

    modport source (output valid, output operation, output sem_id, output pid,
                    output init_value, input ready);
    modport sink   (input valid, input operation, input sem_id, input pid,
                    input init_value, output ready);
endinterface

// ----- hdl/stwq_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwq_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface stwq_out_if;
    logic                              valid;
    logic                              ready;
    logic [stwq_pkg::STATUS_W-1:0]     status;
    logic [stwq_pkg::SEM_ID_W-1:0]     alloc_index;
    logic                              caller_blocks;
    logic                              wake_valid;
    logic [stwq_pkg::PID_W-1:0]        wake_pid;

    modport source (output valid, output status, output alloc_index,
                    output caller_blocks, output wake_valid, output wake_pid,
                    input ready);
    modport sink   (input valid, input status, input alloc_index,
                    input caller_blocks, input wake_valid, input wake_pid,
                    output ready);
endinterface

// ----- hdl/stwq_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwq_alu
// Shared step unit: saturating increment/decrement and wrapping increment.
// ----------------------------------------------------------------------------
module stwq_alu (
    input  stwq_pkg::t_alu_req                  i_req,
    output logic signed [stwq_pkg::VAL_W-1:0]   o_res
);

    logic signed [stwq_pkg::VAL_W:0] w_inc;
    logic signed [stwq_pkg::VAL_W:0] w_dec;

    assign w_inc = {i_req.a[stwq_pkg::VAL_W-1], i_req.a} + 17'sd1;
    assign w_dec = {i_req.a[stwq_pkg::VAL_W-1], i_req.a} - 17'sd1;

    always_comb begin
        unique case (i_req.op)
            stwq_pkg::ALU_INC_SAT: begin
                o_res = (i_req.a < i_req.hi) ? w_inc[stwq_pkg::VAL_W-1:0] : i_req.a;
            end
            stwq_pkg::ALU_DEC_SAT: begin
                o_res = (i_req.a > i_req.lo) ? w_dec[stwq_pkg::VAL_W-1:0] : i_req.a;
            end
            stwq_pkg::ALU_INC_WRAP: begin
                o_res = (i_req.a >= i_req.hi) ? i_req.lo : w_inc[stwq_pkg::VAL_W-1:0];
            end
            default: begin
                o_res = i_req.a;
            end
        endcase
    end

endmodule

// ----- hdl/stwq_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwq_ring
// Wait ring storage for all semaphores, one write and one read port.
// ----------------------------------------------------------------------------
module stwq_ring #(
    parameter int ADDR_W = 11
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [ADDR_W-1:0]                i_waddr,
    input  logic [stwq_pkg::PID_W-1:0]       i_wdata,
    input  logic                             i_re,
    input  logic [ADDR_W-1:0]                i_raddr,
    output logic [stwq_pkg::PID_W-1:0]       o_rdata
);

    logic [stwq_pkg::PID_W-1:0] r_mem [2**ADDR_W];
    logic [stwq_pkg::PID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/semaphore_table_with_wait_queues.sv -----
`timescale 1ns / 1ps
// Flow: wait and signal pass through the LOAD, VAL, PTR, CNT and DONE states; init,
//   unknown operations and out-of-range ids go from LOAD straight to DONE. The shared
//   step unit runs three times per wait or signal. One item at a time: the next is taken
//   only after the last enters the output register; DONE waits while that register is full.
// Reset: synchronous, clears allocation bits and per-semaphore records; the wait ring
//   memory is not cleared, occupancy counts keep unwritten entries from being read.
// ----------------------------------------------------------------------------
// semaphore_table_with_wait_queues
// Counting semaphore table with per-semaphore FIFO wait rings.
// ----------------------------------------------------------------------------
module semaphore_table_with_wait_queues #(
    parameter int NUM_SEMS    = 32,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stwq_in_if.sink     i_in,
    stwq_out_if.source  o_out
);

    localparam int NSEM   = (NUM_SEMS < stwq_pkg::ADDR_LIMIT) ? NUM_SEMS
                                                              : stwq_pkg::ADDR_LIMIT;
    localparam int SIDX_W = (NSEM > 1) ? $clog2(NSEM) : 1;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int VW     = stwq_pkg::VAL_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_VAL  = 6'b000100,
        S_PTR  = 6'b001000,
        S_CNT  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // per-semaphore records
    logic [NSEM-1:0]          r_valid;
    logic signed [VW-1:0]     r_value [NSEM];
    logic [PTR_W-1:0]         r_head  [NSEM];
    logic [PTR_W-1:0]         r_tail  [NSEM];
    logic [CNT_W-1:0]         r_cnt   [NSEM];

    // item and working registers
    stwq_pkg::t_op                    r_op;
    logic [stwq_pkg::SEM_ID_W-1:0]    r_sem_id;
    logic [stwq_pkg::PID_W-1:0]       r_pid;
    logic signed [VW-1:0]             r_init;
    logic [SIDX_W-1:0]                r_slot;
    logic signed [VW-1:0]             r_w_val;
    logic [PTR_W-1:0]                 r_w_head;
    logic [PTR_W-1:0]                 r_w_tail;
    logic [CNT_W-1:0]                 r_w_cnt;
    logic                             r_qop;

    // results in progress
    stwq_pkg::t_status                r_status;
    logic [stwq_pkg::SEM_ID_W-1:0]    r_idx;
    logic                             r_blocks;
    logic                             r_wv;
    logic [stwq_pkg::PID_W-1:0]       r_wpid;

    // output register
    logic                             r_o_valid;
    stwq_pkg::t_status                r_o_status;
    logic [stwq_pkg::SEM_ID_W-1:0]    r_o_idx;
    logic                             r_o_blocks;
    logic                             r_o_wv;
    logic [stwq_pkg::PID_W-1:0]       r_o_wpid;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic                     w_in_range;
    logic [SIDX_W-1:0]        w_rd_idx;
    logic                     w_free_found;
    logic [SIDX_W-1:0]        w_free_idx;
    logic                     w_is_wait;
    logic                     w_act;
    logic                     w_full;
    logic                     w_empty;
    stwq_pkg::t_alu_req       w_alu_req;
    logic signed [VW-1:0]     w_alu_res;
    logic                     w_ring_we;
    logic                     w_ring_re;
    logic [stwq_pkg::PID_W-1:0] w_ring_rdata;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_o_valid || o_out.ready;
    assign w_in_range = (32'(r_sem_id) < NUM_SEMS);
    assign w_rd_idx   = r_sem_id[SIDX_W-1:0];
    assign w_is_wait  = (r_op == stwq_pkg::OP_WAIT);
    assign w_act      = w_is_wait ? r_w_val[VW-1]
                                  : (r_w_val[VW-1] || (r_w_val == '0));
    assign w_full     = (r_w_cnt == CNT_W'(QUEUE_DEPTH));
    assign w_empty    = (r_w_cnt == '0);
    assign w_ring_we  = (r_state == S_PTR) && w_is_wait && w_act && !w_full;
    assign w_ring_re  = (r_state == S_PTR) && (r_op == stwq_pkg::OP_SIGNAL)
                        && w_act && !w_empty;

    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = NSEM - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = SIDX_W'(i);
            end
        end
    end

    always_comb begin
        w_alu_req.op = w_is_wait ? stwq_pkg::ALU_DEC_SAT : stwq_pkg::ALU_INC_SAT;
        w_alu_req.a  = r_w_val;
        w_alu_req.lo = stwq_pkg::VAL_MIN;
        w_alu_req.hi = stwq_pkg::VAL_MAX;
        unique case (r_state)
            S_PTR: begin
                w_alu_req.op = stwq_pkg::ALU_INC_WRAP;
                w_alu_req.a  = w_is_wait ? VW'(r_w_tail) : VW'(r_w_head);
                w_alu_req.lo = '0;
                w_alu_req.hi = VW'(QUEUE_DEPTH - 1);
            end
            S_CNT: begin
                w_alu_req.op = w_is_wait ? stwq_pkg::ALU_INC_SAT : stwq_pkg::ALU_DEC_SAT;
                w_alu_req.a  = VW'(r_w_cnt);
                w_alu_req.lo = '0;
                w_alu_req.hi = VW'(QUEUE_DEPTH);
            end
            default: begin
            end
        endcase
    end

    stwq_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    stwq_ring #(
        .ADDR_W (SIDX_W + PTR_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr ({r_slot, r_w_tail}),
        .i_wdata (r_pid),
        .i_re    (w_ring_re),
        .i_raddr ({r_slot, r_w_head}),
        .o_rdata (w_ring_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_LOAD;
            end
            S_LOAD: begin
                if ((r_op == stwq_pkg::OP_WAIT || r_op == stwq_pkg::OP_SIGNAL)
                    && w_in_range) begin
                    n_state = S_VAL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_VAL:  n_state = S_PTR;
            S_PTR:  n_state = S_CNT;
            S_CNT:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_valid   <= '0;
            for (int i = 0; i < NSEM; i++) begin
                r_value[i] <= '0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_cnt[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op     <= stwq_pkg::t_op'(i_in.operation);
                        r_sem_id <= i_in.sem_id;
                        r_pid    <= i_in.pid;
                        r_init   <= i_in.init_value;
                        r_status <= stwq_pkg::ST_OK;
                        r_idx    <= '0;
                        r_blocks <= 1'b0;
                        r_wv     <= 1'b0;
                        r_wpid   <= '0;
                        r_qop    <= 1'b0;
                    end
                end
                S_LOAD: begin
                    r_slot   <= w_rd_idx;
                    r_w_val  <= r_value[w_rd_idx];
                    r_w_head <= r_head[w_rd_idx];
                    r_w_tail <= r_tail[w_rd_idx];
                    r_w_cnt  <= r_cnt[w_rd_idx];
                    if (r_op == stwq_pkg::OP_INIT) begin
                        if (w_free_found) begin
                            r_valid[w_free_idx] <= 1'b1;
                            r_value[w_free_idx] <= r_init;
                            r_idx <= stwq_pkg::SEM_ID_W'(w_free_idx);
                        end else begin
                            r_status <= stwq_pkg::ST_NO_FREE;
                        end
                    end
                end
                S_VAL: begin
                    r_w_val <= w_alu_res;
                end
                S_PTR: begin
                    if (w_act) begin
                        if (w_is_wait) begin
                            r_blocks <= 1'b1;
                            if (w_full) begin
                                r_status <= stwq_pkg::ST_QUEUE_FULL;
                            end else begin
                                r_qop    <= 1'b1;
                                r_w_tail <= w_alu_res[PTR_W-1:0];
                            end
                        end else begin
                            if (w_empty) begin
                                r_status <= stwq_pkg::ST_NOTHING;
                            end else begin
                                r_qop    <= 1'b1;
                                r_w_head <= w_alu_res[PTR_W-1:0];
                            end
                        end
                    end
                end
                S_CNT: begin
                    r_value[r_slot] <= r_w_val;
                    r_head[r_slot]  <= r_w_head;
                    r_tail[r_slot]  <= r_w_tail;
                    r_cnt[r_slot]   <= r_qop ? w_alu_res[CNT_W-1:0] : r_w_cnt;
                    if (r_qop && !w_is_wait) begin
                        r_wv   <= 1'b1;
                        r_wpid <= w_ring_rdata;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_status <= r_status;
                        r_o_idx    <= r_idx;
                        r_o_blocks <= r_blocks;
                        r_o_wv     <= r_wv;
                        r_o_wpid   <= r_wpid;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.status        = r_o_status;
    assign o_out.alloc_index   = r_o_idx;
    assign o_out.caller_blocks = r_o_blocks;
    assign o_out.wake_valid    = r_o_wv;
    assign o_out.wake_pid      = r_o_wpid;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT) |-> (r_w_cnt <= CNT_W'(QUEUE_DEPTH)))
        else $error("occupancy count beyond ring depth");

    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_wv) |-> ((r_o_status == stwq_pkg::ST_OK) && !r_o_blocks))
        else $error("wake item with bad status");

    a_ring_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ring_we && w_ring_re))
        else $error("ring written and read by one item");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_LOAD))
        else $error("accepted item not loaded");

endmodule

// ----- tb/stwq_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwq_result_checker
// Watches the operation and result channels of the semaphore table, keeps
// its own copy of the semaphore values and wait rings, predicts the result
// of every accepted operation and compares each accepted result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module stwq_result_checker #(
    parameter int NUM_SEMS    = 32,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    stwq_in_if   i_ops,
    stwq_out_if  i_results,
    output int   o_fail_count,
    output int   o_outstanding
);

    typedef struct packed {
        stwq_pkg::t_status                status;
        logic [stwq_pkg::SEM_ID_W-1:0]    alloc_index;
        logic                             caller_blocks;
        logic                             wake_valid;
        logic [stwq_pkg::PID_W-1:0]       wake_pid;
    } t_outcome;

    logic                             sem_taken   [NUM_SEMS];
    logic signed [stwq_pkg::VAL_W-1:0] sem_count  [NUM_SEMS];
    logic [stwq_pkg::PID_W-1:0]       waiter_pid  [NUM_SEMS][QUEUE_DEPTH];
    int                               ring_rd     [NUM_SEMS];
    int                               ring_wr     [NUM_SEMS];
    int                               ring_fill   [NUM_SEMS];

    t_outcome pending_outcomes [$];
    t_outcome oldest;
    int       failures = 0;
    int       queued   = 0;

    assign o_fail_count  = failures;
    assign o_outstanding = queued;

    function automatic t_outcome next_outcome(stwq_pkg::t_op op,
                                              logic [stwq_pkg::SEM_ID_W-1:0] sid,
                                              logic [stwq_pkg::PID_W-1:0] pid,
                                              logic signed [stwq_pkg::VAL_W-1:0] value);
        t_outcome r;
        int       lim;
        int       slot;
        r        = '0;
        r.status = stwq_pkg::ST_OK;
        lim      = (NUM_SEMS < stwq_pkg::ADDR_LIMIT) ? NUM_SEMS : stwq_pkg::ADDR_LIMIT;
        if (op == stwq_pkg::OP_INIT) begin
            slot = lim;
            for (int i = lim - 1; i >= 0; i--) begin
                if (!sem_taken[i]) slot = i;
            end
            if (slot == lim) begin
                r.status = stwq_pkg::ST_NO_FREE;
            end else begin
                sem_taken[slot] = 1'b1;
                sem_count[slot] = value;
                r.alloc_index   = slot[stwq_pkg::SEM_ID_W-1:0];
            end
        end else if (op == stwq_pkg::OP_WAIT && sid < NUM_SEMS) begin
            if (sem_count[sid] != stwq_pkg::VAL_MIN) sem_count[sid] = sem_count[sid] - 16'sd1;
            if (sem_count[sid] < 0) begin
                r.caller_blocks = 1'b1;
                if (ring_fill[sid] >= QUEUE_DEPTH) begin
                    r.status = stwq_pkg::ST_QUEUE_FULL;
                end else begin
                    waiter_pid[sid][ring_wr[sid]] = pid;
                    ring_wr[sid]   = (ring_wr[sid] + 1) % QUEUE_DEPTH;
                    ring_fill[sid] = ring_fill[sid] + 1;
                end
            end
        end else if (op == stwq_pkg::OP_SIGNAL && sid < NUM_SEMS) begin
            if (sem_count[sid] != stwq_pkg::VAL_MAX) sem_count[sid] = sem_count[sid] + 16'sd1;
            if (sem_count[sid] <= 0) begin
                if (ring_fill[sid] == 0) begin
                    r.status = stwq_pkg::ST_NOTHING;
                end else begin
                    r.wake_valid   = 1'b1;
                    r.wake_pid     = waiter_pid[sid][ring_rd[sid]];
                    ring_rd[sid]   = (ring_rd[sid] + 1) % QUEUE_DEPTH;
                    ring_fill[sid] = ring_fill[sid] - 1;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got) begin
            failures++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SEMS; s++) begin
                sem_taken[s] = 1'b0;
                sem_count[s] = '0;
                ring_rd[s]   = 0;
                ring_wr[s]   = 0;
                ring_fill[s] = 0;
            end
            pending_outcomes.delete();
            queued = 0;
        end else begin
            if (i_ops.valid && i_ops.ready) begin
                pending_outcomes.push_back(next_outcome(stwq_pkg::t_op'(i_ops.operation),
                                                        i_ops.sem_id, i_ops.pid,
                                                        i_ops.init_value));
            end
            if (i_results.valid && i_results.ready) begin
                if (pending_outcomes.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result: expected none, actual status %0d",
                             $time, i_results.status);
                end else begin
                    oldest = pending_outcomes.pop_front();
                    check_field("status", oldest.status, i_results.status);
                    check_field("alloc_index", oldest.alloc_index, i_results.alloc_index);
                    check_field("caller_blocks", oldest.caller_blocks,
                                i_results.caller_blocks);
                    check_field("wake_valid", oldest.wake_valid, i_results.wake_valid);
                    check_field("wake_pid", oldest.wake_pid, i_results.wake_pid);
                end
            end
            queued = pending_outcomes.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the semaphore table with directed operations (value extremes,
// saturation, pid zero, empty and full wait rings, table exhaustion) and
// then with random wait/signal runs, inits and noise, under bursty input
// and a stalling result side. The checker beside the block does the
// prediction; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_SEMS    = 32;
    localparam int QUEUE_DEPTH = 64;
    localparam int OP_TARGET   = 950;
    localparam int SETTLE      = 20;
    localparam int PID_W       = stwq_pkg::PID_W;
    localparam int VAL_W       = stwq_pkg::VAL_W;
    localparam int SEM_ID_W    = stwq_pkg::SEM_ID_W;

    typedef enum int {
        RDY_ON,
        RDY_OFF,
        RDY_TOGGLE,
        RDY_RANDOM
    } t_ready_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    int   ops_sent    = 0;
    int   inits_sent  = 0;
    int   burst_left  = 0;

    stwq_in_if  op_ch ();
    stwq_out_if res_ch ();

    semaphore_table_with_wait_queues #(
        .NUM_SEMS    (NUM_SEMS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    stwq_result_checker #(
        .NUM_SEMS    (NUM_SEMS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ops         (op_ch),
        .i_results     (res_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [PID_W-1:0] any_pid();
        return PID_W'($urandom_range(1, 1023));
    endfunction

    function automatic logic signed [VAL_W-1:0] any_init_value();
        if ($urandom_range(0, 3) == 0) return VAL_W'($urandom);
        return VAL_W'(int'($urandom_range(0, 8)) - 4);
    endfunction

    // Offer one item, opening a new burst after a random gap when due.
    task automatic send_op(stwq_pkg::t_op op, int sid, logic [PID_W-1:0] pid,
                           logic signed [VAL_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                op_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        op_ch.valid      <= 1'b1;
        op_ch.operation  <= op;
        op_ch.sem_id     <= sid[SEM_ID_W-1:0];
        op_ch.pid        <= pid;
        op_ch.init_value <= value;
        do @(posedge i_clk); while (!op_ch.ready);
        burst_left--;
        if (op != stwq_pkg::OP_NONE) ops_sent++;
        if (op == stwq_pkg::OP_INIT) inits_sent++;
    endtask

    // Hold the input until every predicted result has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        op_ch.valid <= 1'b0;
        burst_left = 0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic wait_signal_run(int sid, int n_waits, int n_signals);
        repeat (n_waits) send_op(stwq_pkg::OP_WAIT, sid, any_pid(), any_init_value());
        repeat (n_signals) send_op(stwq_pkg::OP_SIGNAL, sid, any_pid(), any_init_value());
    endtask

    initial begin : result_ready_pattern
        t_ready_mode mode;
        int          pick;
        int          run;
        int          elapsed;
        bit          long_hold_done;
        res_ch.ready   = 1'b0;
        elapsed        = 0;
        long_hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            pick = $urandom_range(0, 9);
            run  = $urandom_range(4, 40);
            if (pick < 4) mode = RDY_ON;
            else if (pick < 8) mode = RDY_RANDOM;
            else if (pick == 8) mode = RDY_OFF;
            else mode = RDY_TOGGLE;
            if (!long_hold_done && elapsed >= 600) begin
                long_hold_done = 1'b1;
                mode = RDY_OFF;
                run  = 150;
            end
            for (int c = 0; c < run; c++) begin
                @(negedge i_clk);
                case (mode)
                    RDY_ON:     res_ch.ready <= 1'b1;
                    RDY_OFF:    res_ch.ready <= 1'b0;
                    RDY_TOGGLE: res_ch.ready <= c[0];
                    default:    res_ch.ready <= 1'($urandom_range(0, 1));
                endcase
                elapsed++;
            end
        end
    end

    initial begin : stimulus
        int  pick;
        int  sid;
        int  n_waits;
        int  steps;
        bit  midpoint_done;
        op_ch.valid      = 1'b0;
        op_ch.operation  = stwq_pkg::OP_INIT;
        op_ch.sem_id     = '0;
        op_ch.pid        = '0;
        op_ch.init_value = '0;
        i_rst_n          = 1'b0;
        midpoint_done    = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_op(stwq_pkg::OP_INIT, 0, 10'd1, stwq_pkg::VAL_MAX);
        send_op(stwq_pkg::OP_INIT, 0, 10'd1, stwq_pkg::VAL_MIN);
        send_op(stwq_pkg::OP_INIT, 0, 10'd1, 16'sd0);
        send_op(stwq_pkg::OP_INIT, 0, 10'd1, -16'sd1);
        send_op(stwq_pkg::OP_SIGNAL, 0, 10'd2, 16'sd0);
        send_op(stwq_pkg::OP_WAIT, 1, 10'd1023, 16'sd0);
        send_op(stwq_pkg::OP_WAIT, 1, 10'd0, 16'sd0);
        send_op(stwq_pkg::OP_SIGNAL, 1, 10'd3, 16'sd0);
        send_op(stwq_pkg::OP_SIGNAL, 1, 10'd3, 16'sd0);
        send_op(stwq_pkg::OP_SIGNAL, 1, 10'd3, 16'sd0);
        send_op(stwq_pkg::OP_WAIT, 2, 10'h2AA, 16'sd0);
        send_op(stwq_pkg::OP_SIGNAL, 2, 10'h155, 16'sd0);
        send_op(stwq_pkg::OP_SIGNAL, 2, 10'h155, 16'sd0);
        send_op(stwq_pkg::OP_WAIT, 3, 10'h155, 16'sd0);
        send_op(stwq_pkg::OP_NONE, 31, 10'd1023, -16'sd1);
        send_op(stwq_pkg::OP_WAIT, 31, 10'd1, 16'sd0);
        send_op(stwq_pkg::OP_SIGNAL, 31, 10'd5, 16'sd0);
        send_op(stwq_pkg::OP_INIT, 0, 10'd1, 16'sh5555);
        send_op(stwq_pkg::OP_INIT, 0, 10'd1, 16'shAAAA);
        send_op(stwq_pkg::OP_SIGNAL, 30, 10'd7, 16'sd0);
        send_op(stwq_pkg::OP_WAIT, 30, 10'd8, 16'sd0);
        drain_results();

        // overflow one ring, then drain it past empty
        wait_signal_run($urandom_range(16, 31), QUEUE_DEPTH + 6, QUEUE_DEPTH + 8);

        while (ops_sent < OP_TARGET) begin
            if (!midpoint_done && ops_sent >= OP_TARGET / 2) begin
                midpoint_done = 1'b1;
                drain_results();
                while (inits_sent < stwq_pkg::ADDR_LIMIT + 2) begin
                    send_op(stwq_pkg::OP_INIT, 0, any_pid(), any_init_value());
                end
            end
            pick = $urandom_range(0, 19);
            sid  = $urandom_range(0, NUM_SEMS - 1);
            if (pick < 9) begin
                n_waits = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72)
                                                      : $urandom_range(1, 8);
                wait_signal_run(sid, n_waits, n_waits + $urandom_range(0, 2));
            end else if (pick < 13) begin
                steps = $urandom_range(4, 20);
                repeat (steps) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_op(stwq_pkg::OP_WAIT, sid, any_pid(), any_init_value());
                    end else begin
                        send_op(stwq_pkg::OP_SIGNAL, sid, any_pid(), any_init_value());
                    end
                end
            end else if (pick < 15) begin
                send_op(stwq_pkg::OP_INIT, sid, any_pid(), any_init_value());
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_op(stwq_pkg::t_op'($urandom_range(0, 3)), $urandom_range(0, 31),
                            PID_W'($urandom_range(0, 1023)), VAL_W'($urandom));
                end
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
